FILE: rtl/core/qalu_pkg.sv
// Package for the quaternion ALU: payload structs, operation codes,
// datapath widths and the rounding and clamping functions.
// No dependencies; every other file in rtl/core imports it.
package qalu_pkg;

  localparam int DEFAULT_FRAC_BITS = 16;
  localparam int ROOT_EXTRA = 30;
  localparam int FIFO_DEPTH = 4;

  localparam int COMP_W = 32;
  localparam int PROD_W = 64;
  localparam int SUM_W  = 66;
  localparam int PPH_W  = 66;
  localparam int PPL_W  = 65;
  localparam int WIDE_W = 100;
  localparam int SQ_W   = 126;
  localparam int SQ_TOP = 2 * (ROOT_EXTRA + 32);
  localparam int QUO_W  = 33;
  localparam int SH_W   = 7;

  localparam int IX = 0;
  localparam int IY = 1;
  localparam int IZ = 2;
  localparam int IW = 3;

  // Request codes, reused as work classes; K_NONE yields an all-zero result.
  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_INV  = 3'd1;
  localparam logic [2:0] OP_ROT  = 3'd2;
  localparam logic [2:0] OP_NORM = 3'd3;
  localparam logic [2:0] OP_DOT  = 3'd4;
  localparam logic [2:0] K_NONE  = 3'd5;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic [2:0] req_type;
    comp_t      a_x;
    comp_t      a_y;
    comp_t      a_z;
    comp_t      a_w;
    comp_t      b_x;
    comp_t      b_y;
    comp_t      b_z;
    comp_t      b_w;
  } qalu_req_t;

  typedef struct packed {
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    comp_t r_w;
    logic  zero_length;
    logic  saturated;
  } qalu_res_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic             zl;
    comp_t [3:0]      a;
    comp_t [3:0]      b;
  } qalu_entry_t;

  typedef struct packed {
    logic                  start;
    logic                  norm;
    logic [3:0]            neg;
    logic [3:0][SUM_W-1:0] mag;
    logic [SUM_W-1:0]      den;
  } qalu_iter_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } qalu_iter_stat_t;

  typedef struct packed {
    logic [COMP_W-1:0] val;
    logic              sat;
  } qalu_fin_t;

  // Clamp a sign and magnitude to the 32-bit two's complement range.
  function automatic qalu_fin_t fin_mag(input logic neg, input logic [WIDE_W:0] m);
    logic [WIDE_W:0]   lim;
    logic [COMP_W-1:0] m32;
    qalu_fin_t         f;
    lim = neg ? (WIDE_W+1)'(33'h080000000) : (WIDE_W+1)'(33'h07fffffff);
    if (m > lim) begin
      m32 = lim[COMP_W-1:0];
      f.sat = 1'b1;
    end else begin
      m32 = m[COMP_W-1:0];
      f.sat = 1'b0;
    end
    f.val = neg ? (~m32 + 32'd1) : m32;
    return f;
  endfunction

  // Divide by 2^s with rounding half away from zero, then clamp; s is at least one.
  function automatic qalu_fin_t fin_shift(input logic signed [WIDE_W-1:0] v,
                                          input logic [SH_W-1:0] s);
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W:0]   sum;
    logic [WIDE_W:0]   q;
    logic              neg;
    mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    sum = {1'b0, mag} + ((WIDE_W+1)'(1) << (s - 7'd1));
    q = sum >> s;
    neg = v[WIDE_W-1] && (q != '0);
    return fin_mag(neg, q);
  endfunction

endpackage

FILE: rtl/core/quaternion_alu_core.sv
// Multiply, rotate and dot pass from the request queue through stages s1 to s5
// into the result register; multiply by inverse (33-step divider) and normalize
// (63-step square root, then the divider) go on from s5 to the iterative unit,
// which holds the whole back end while busy. Throughput: one item per cycle for
// multiply, rotate and dot while neither the unit nor a stalled result holds it.
// Reset clears the queue, valid bits and iterative unit; nothing else needs it.
module quaternion_alu_core
  import qalu_pkg::*;
#(
  parameter int FRAC_BITS   = DEFAULT_FRAC_BITS,
  parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  qalu_req_t req_data,
  output logic      res_valid,
  input  logic      res_stall,
  output qalu_res_t res_data
);

  logic        head_valid;
  qalu_entry_t head;
  logic        pop;

  qalu_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  qalu_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

FILE: rtl/core/qalu_front.sv
// Front end of the quaternion ALU: classifies requests and queues them.
// Depends on qalu_pkg.
module qalu_front
  import qalu_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  qalu_req_t   req_data,
  input  logic        pop,
  output logic        head_valid,
  output qalu_entry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qalu_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  qalu_entry_t      entry;
  logic             a_zero;
  logic             b_zero;
  logic             push;

  assign a_zero = (req_data.a_x == '0) && (req_data.a_y == '0) &&
                  (req_data.a_z == '0) && (req_data.a_w == '0);
  assign b_zero = (req_data.b_x == '0) && (req_data.b_y == '0) &&
                  (req_data.b_z == '0) && (req_data.b_w == '0);

  always_comb begin
    entry.a = {req_data.a_w, req_data.a_z, req_data.a_y, req_data.a_x};
    entry.b = {req_data.b_w, req_data.b_z, req_data.b_y, req_data.b_x};
    entry.zl = 1'b0;
    unique case (req_data.req_type)
      OP_MUL:  entry.kind = OP_MUL;
      OP_ROT:  entry.kind = OP_ROT;
      OP_DOT:  entry.kind = OP_DOT;
      OP_INV: begin
        entry.kind = b_zero ? K_NONE : OP_INV;
        entry.zl = b_zero;
      end
      OP_NORM: begin
        entry.kind = a_zero ? K_NONE : OP_NORM;
        entry.zl = a_zero;
      end
      default: entry.kind = K_NONE;
    endcase
  end

  assign req_stall = (count == CNT_W'(DEPTH));
  assign push = req_valid && !req_stall;
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

FILE: rtl/core/qalu_iter.sv
// Iterative unit of the quaternion ALU: square root and restoring division
// for normalize and multiply-by-inverse, four quotient lanes. Depends on qalu_pkg.
module qalu_iter
  import qalu_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  qalu_iter_cmd_t  cmd,
  input  logic            ack,
  output qalu_iter_stat_t stat,
  output qalu_res_t       res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQRT  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int SH_INV  = FRAC_BITS + 1;
  localparam int SH_NORM = FRAC_BITS + 1 + ROOT_EXTRA;

  logic [2:0]              state;
  logic                    norm;
  logic [3:0]              neg;
  logic [3:0][SUM_W-1:0]   mag;
  logic [SUM_W-1:0]        base;
  logic [SQ_W-1:0]         x;
  logic [SQ_W-1:0]         root;
  logic [SQ_W-1:0]         bitr;
  logic [3:0][WIDE_W-1:0]  rem;
  logic [WIDE_W-1:0]       ds;
  logic [3:0][QUO_W-1:0]   quo;
  logic [5:0]              cnt;

  logic [SQ_W-1:0]         sq_t;
  logic                    sq_ge;
  logic [SQ_W-1:0]         root_next;
  logic [3:0]              dv_ge;
  qalu_fin_t [3:0]         fin;

  always_comb begin
    sq_t = root + bitr;
    sq_ge = (x >= sq_t);
    root_next = sq_ge ? ((root >> 1) + bitr) : (root >> 1);
    for (int k = 0; k < 4; k++) begin
      dv_ge[k] = (rem[k] >= ds);
      fin[k] = fin_mag(neg[k] && (quo[k] != '0), (WIDE_W+1)'(quo[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            state <= cmd.norm ? ST_SQRT : ST_SETUP;
          end
        end
        ST_SQRT: begin
          if (bitr[0]) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: state <= ST_DIV;
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        norm <= cmd.norm;
        neg <= cmd.neg;
        mag <= cmd.mag;
        base <= cmd.den;
        x <= SQ_W'(cmd.den) << (2 * ROOT_EXTRA);
        root <= '0;
        bitr <= SQ_W'(1) << SQ_TOP;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          x <= x - sq_t;
        end
        root <= root_next;
        bitr <= bitr >> 2;
        if (bitr[0]) begin
          base <= root_next[SUM_W-1:0];
        end
      end
      ST_SETUP: begin
        for (int k = 0; k < 4; k++) begin
          rem[k] <= (norm ? (WIDE_W'(mag[k]) << SH_NORM) : (WIDE_W'(mag[k]) << SH_INV))
                    + WIDE_W'(base);
          quo[k] <= '0;
        end
        // The first step tests the quotient bit worth 2^32 against twice the base.
        ds <= WIDE_W'(base) << QUO_W;
        cnt <= 6'(QUO_W - 1);
      end
      ST_DIV: begin
        for (int k = 0; k < 4; k++) begin
          if (dv_ge[k]) begin
            rem[k] <= rem[k] - ds;
          end
          quo[k] <= {quo[k][QUO_W-2:0], dv_ge[k]};
        end
        ds <= ds >> 1;
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_DONE);

  assign res.r_x = comp_t'(fin[IX].val);
  assign res.r_y = comp_t'(fin[IY].val);
  assign res.r_z = comp_t'(fin[IZ].val);
  assign res.r_w = comp_t'(fin[IW].val);
  assign res.zero_length = 1'b0;
  assign res.saturated = fin[IX].sat | fin[IY].sat | fin[IZ].sat | fin[IW].sat;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> ds != '0)
    else $error("division step with a zero divisor");
`endif

endmodule

FILE: rtl/core/qalu_back.sv
// Back end of the quaternion ALU: five-stage product and sum pipeline,
// rounding, the iterative unit and the result register. Depends on qalu_pkg, qalu_iter.
module qalu_back
  import qalu_pkg::*;
#(
  parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  qalu_entry_t head,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_stall,
  output qalu_res_t   res_data
);

  localparam logic [SH_W-1:0] SH_ONE = SH_W'(FRAC_BITS);
  localparam logic [SH_W-1:0] SH_TWO = SH_W'(2 * FRAC_BITS);

  qalu_iter_cmd_t  cmd;
  qalu_iter_stat_t stat;
  qalu_res_t       unit_res;
  logic            adv;
  logic            out_free;
  logic            s5_div;
  logic            pipe_load;
  logic            unit_load;

  // Stage 1: all products of A with B (with A for normalize) and squares of B.
  comp_t [3:0]              bsel;
  logic signed [PROD_W-1:0] p_c [4][4];
  logic signed [PROD_W-1:0] q_c [4];
  logic                     s1_valid;
  logic [2:0]               s1_kind;
  logic                     s1_zl;
  comp_t [3:0]              s1_a;
  comp_t [3:0]              s1_b;
  logic signed [PROD_W-1:0] s1_p [4][4];
  logic signed [PROD_W-1:0] s1_q [4];

  always_comb begin
    bsel = (head.kind == OP_NORM) ? head.a : head.b;
    for (int i = 0; i < 4; i++) begin
      q_c[i] = $signed(head.b[i]) * $signed(head.b[i]);
      for (int j = 0; j < 4; j++) begin
        p_c[i][j] = $signed(head.a[i]) * $signed(bsel[j]);
      end
    end
  end

  // Stage 2: component sums, selected by operation.
  logic signed [SUM_W-1:0] e [4][4];
  logic signed [SUM_W-1:0] hv [4];
  logic signed [SUM_W-1:0] iv [4];
  logic signed [SUM_W-1:0] c1 [3];
  logic signed [SUM_W-1:0] nsum;
  logic signed [SUM_W-1:0] v2_c [4];
  logic [SUM_W-1:0]        den2_c;
  logic                    s2_valid;
  logic [2:0]              s2_kind;
  logic                    s2_zl;
  comp_t [3:0]             s2_a;
  comp_t [3:0]             s2_b;
  logic signed [SUM_W-1:0] s2_v [4];
  logic [SUM_W-1:0]        s2_den;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = SUM_W'(s1_p[i][j]);
      end
    end
    hv[IX] = e[IX][IW] + e[IW][IX] + e[IY][IZ] - e[IZ][IY];
    hv[IY] = e[IY][IW] + e[IW][IY] + e[IZ][IX] - e[IX][IZ];
    hv[IZ] = e[IZ][IW] + e[IW][IZ] + e[IX][IY] - e[IY][IX];
    hv[IW] = e[IW][IW] - e[IX][IX] - e[IY][IY] - e[IZ][IZ];
    iv[IX] = e[IX][IW] - e[IW][IX] - e[IY][IZ] + e[IZ][IY];
    iv[IY] = e[IY][IW] - e[IW][IY] - e[IZ][IX] + e[IX][IZ];
    iv[IZ] = e[IZ][IW] - e[IW][IZ] - e[IX][IY] + e[IY][IX];
    iv[IW] = e[IW][IW] + e[IX][IX] + e[IY][IY] + e[IZ][IZ];
    c1[IX] = e[IY][IZ] - e[IZ][IY];
    c1[IY] = e[IZ][IX] - e[IX][IZ];
    c1[IZ] = e[IX][IY] - e[IY][IX];
    nsum = SUM_W'(s1_q[IX]) + SUM_W'(s1_q[IY]) + SUM_W'(s1_q[IZ]) + SUM_W'(s1_q[IW]);
    den2_c = '0;
    for (int k = 0; k < 4; k++) begin
      v2_c[k] = '0;
    end
    case (s1_kind)
      OP_MUL: begin
        for (int k = 0; k < 4; k++) begin
          v2_c[k] = hv[k];
        end
      end
      OP_INV: begin
        for (int k = 0; k < 4; k++) begin
          v2_c[k] = iv[k];
        end
        den2_c = nsum;
      end
      OP_ROT: begin
        for (int k = 0; k < 3; k++) begin
          v2_c[k] = c1[k];
        end
      end
      OP_NORM: begin
        // With B replaced by A, the dot sum is the squared length of A.
        for (int k = 0; k < 4; k++) begin
          v2_c[k] = SUM_W'(s1_a[k]);
        end
        den2_c = iv[IW];
      end
      OP_DOT: v2_c[IW] = iv[IW];
      default: ;
    endcase
  end

  // Stage 3: cross products times A, each split into high and low partial products.
  logic                    s3_valid;
  logic [2:0]              s3_kind;
  logic                    s3_zl;
  comp_t [3:0]             s3_b;
  logic signed [SUM_W-1:0] s3_v [4];
  logic [SUM_W-1:0]        s3_den;
  logic signed [PPH_W-1:0] s3_pph [3][4];
  logic signed [PPL_W-1:0] s3_ppl [3][4];
  logic signed [PPH_W-1:0] pph_c [3][4];
  logic signed [PPL_W-1:0] ppl_c [3][4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 4; j++) begin
        pph_c[k][j] = $signed(s2_v[k][SUM_W-1:32]) * $signed(s2_a[j]);
        ppl_c[k][j] = $signed({1'b0, s2_v[k][31:0]}) * $signed(s2_a[j]);
      end
    end
  end

  // Stage 4: full products.
  logic                     s4_valid;
  logic [2:0]               s4_kind;
  logic                     s4_zl;
  comp_t [3:0]              s4_b;
  logic signed [SUM_W-1:0]  s4_v [4];
  logic [SUM_W-1:0]         s4_den;
  logic signed [WIDE_W-1:0] s4_t [3][4];
  logic signed [WIDE_W-1:0] t_c [3][4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 4; j++) begin
        t_c[k][j] = (WIDE_W'(s3_pph[k][j]) <<< 32) + WIDE_W'(s3_ppl[k][j]);
      end
    end
  end

  // Stage 5: rotated vector sums; other operations pass through widened.
  logic signed [WIDE_W-1:0] c2 [3];
  logic signed [WIDE_W-1:0] v5_c [4];
  logic                     s5_valid;
  logic [2:0]               s5_kind;
  logic                     s5_zl;
  logic signed [WIDE_W-1:0] s5_v [4];
  logic [SUM_W-1:0]         s5_den;

  always_comb begin
    c2[IX] = s4_t[IZ][IY] - s4_t[IY][IZ];
    c2[IY] = s4_t[IX][IZ] - s4_t[IZ][IX];
    c2[IZ] = s4_t[IY][IX] - s4_t[IX][IY];
    for (int k = 0; k < 4; k++) begin
      v5_c[k] = WIDE_W'(s4_v[k]);
    end
    if (s4_kind == OP_ROT) begin
      for (int k = 0; k < 3; k++) begin
        v5_c[k] = (WIDE_W'(s4_b[k]) <<< (2 * FRAC_BITS)) + ((s4_t[k][IW] + c2[k]) <<< 1);
      end
      v5_c[IW] = '0;
    end
  end

  // Rounding of the streamed operations, and the command to the iterative unit.
  logic [SH_W-1:0]  sh5;
  qalu_fin_t [3:0]  fin;
  qalu_res_t        pipe_res;

  always_comb begin
    sh5 = (s5_kind == OP_ROT) ? SH_TWO : SH_ONE;
    for (int k = 0; k < 4; k++) begin
      fin[k] = fin_shift(s5_v[k], sh5);
      cmd.neg[k] = s5_v[k][WIDE_W-1];
      cmd.mag[k] = s5_v[k][WIDE_W-1] ? SUM_W'(-s5_v[k]) : SUM_W'(s5_v[k]);
    end
    pipe_res.r_x = comp_t'(fin[IX].val);
    pipe_res.r_y = comp_t'(fin[IY].val);
    pipe_res.r_z = comp_t'(fin[IZ].val);
    pipe_res.r_w = comp_t'(fin[IW].val);
    pipe_res.zero_length = s5_zl;
    pipe_res.saturated = fin[IX].sat | fin[IY].sat | fin[IZ].sat | fin[IW].sat;
    cmd.norm = (s5_kind == OP_NORM);
    cmd.den = s5_den;
    cmd.start = adv && s5_div;
  end

  assign s5_div = s5_valid && ((s5_kind == OP_INV) || (s5_kind == OP_NORM));
  assign out_free = !res_valid || !res_stall;
  // The whole pipeline holds while the iterative unit owns the item ahead.
  assign adv = !stat.busy && (!s5_valid || s5_div || out_free);
  assign pop = adv && head_valid;
  assign pipe_load = adv && s5_valid && !s5_div;
  assign unit_load = stat.done && out_free;

  qalu_iter #(
    .FRAC_BITS(FRAC_BITS)
  ) u_iter (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .ack (unit_load),
    .stat(stat),
    .res (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= head_valid;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
        s4_valid <= s3_valid;
        s5_valid <= s4_valid;
      end
      if (pipe_load || unit_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind <= head.kind;
      s1_zl <= head.zl;
      s1_a <= head.a;
      s1_b <= head.b;
      s1_p <= p_c;
      s1_q <= q_c;
      s2_kind <= s1_kind;
      s2_zl <= s1_zl;
      s2_a <= s1_a;
      s2_b <= s1_b;
      s2_v <= v2_c;
      s2_den <= den2_c;
      s3_kind <= s2_kind;
      s3_zl <= s2_zl;
      s3_b <= s2_b;
      s3_v <= s2_v;
      s3_den <= s2_den;
      s3_pph <= pph_c;
      s3_ppl <= ppl_c;
      s4_kind <= s3_kind;
      s4_zl <= s3_zl;
      s4_b <= s3_b;
      s4_v <= s3_v;
      s4_den <= s3_den;
      s4_t <= t_c;
      s5_kind <= s4_kind;
      s5_zl <= s4_zl;
      s5_v <= v5_c;
      s5_den <= s4_den;
    end
    if (pipe_load) begin
      res_data <= pipe_res;
    end else if (unit_load) begin
      res_data <= unit_res;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !adv && !pop)
    else $error("pipeline moved while the iterative unit was busy");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.zero_length |->
      res_data.r_x == '0 && res_data.r_y == '0 && res_data.r_z == '0 &&
      res_data.r_w == '0 && !res_data.saturated)
    else $error("zero-length result carries nonzero data");
`endif

endmodule
